// ===== rtl/hnm_pkg.sv =====
// Shared types and constants for the height to normal map block.
`default_nettype none

package hnm_pkg;

  // Input item kinds.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_MIRROR = 2'd3;

  // Normal component selectors.
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // The z term is 256*255, its square is fixed.
  localparam logic [15:0] Z_COMP    = 16'd65280;
  localparam logic [31:0] Z_SQ      = 32'd4261478400;
  localparam logic [6:0]  NORM_MAX  = 7'd127;
  localparam logic [7:0]  ENC_MID   = 8'd128;
  localparam logic [2:0]  TRIAL_MSB = 3'd6;

  // Widths of the fixed-point datapath.
  localparam int LEN_W = 50;
  localparam int HALF_W = 25;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SCALE, ST_SQX, ST_SQY, ST_MAG, ST_RHS,
    ST_TSQ, ST_PLO, ST_PHI, ST_CMP, ST_OUT
  } hnm_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCALE, OP_SQX, OP_SQY, OP_MAG, OP_RHS,
    OP_TSQ, OP_PLO, OP_PHI, OP_CMP, OP_OUT
  } hnm_op_t;

  typedef struct packed {
    logic       take;
    hnm_op_t    op;
    logic [1:0] comp;
    logic [2:0] bitsel;
  } hnm_cmd_t;

  typedef struct packed {
    logic will_emit;
    logic out_free;
  } hnm_status_t;

endpackage

`default_nettype wire

// ===== rtl/hnm_ctrl.sv =====
// Sequencer for the height to normal map datapath.
`default_nettype none

module hnm_ctrl import hnm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  output logic        s_ready,
  input  hnm_status_t status,
  output hnm_cmd_t    cmd
);

  hnm_state_t state, state_next;
  logic [1:0] comp;
  logic [2:0] bitsel;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Component and trial-bit counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      comp   <= COMP_X;
      bitsel <= TRIAL_MSB;
    end else begin
      case (state)
        ST_IDLE: comp <= COMP_X;
        ST_RHS:  bitsel <= TRIAL_MSB;
        ST_CMP: begin
          if (bitsel == 3'd0) begin
            comp <= comp + 2'd1;
          end else begin
            bitsel <= bitsel - 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    s_ready    = 1'b0;
    cmd.take   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.comp   = comp;
    cmd.bitsel = bitsel;
    case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.take = 1'b1;
          if (status.will_emit) state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op = OP_LOAD;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = ST_SQX;
      end
      ST_SQX: begin
        cmd.op = OP_SQX;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op = OP_SQY;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.op = OP_MAG;
        state_next = ST_RHS;
      end
      ST_RHS: begin
        cmd.op = OP_RHS;
        state_next = ST_TSQ;
      end
      ST_TSQ: begin
        cmd.op = OP_TSQ;
        state_next = ST_PLO;
      end
      ST_PLO: begin
        cmd.op = OP_PLO;
        state_next = ST_PHI;
      end
      ST_PHI: begin
        cmd.op = OP_PHI;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.op = OP_CMP;
        if (bitsel != 3'd0) begin
          state_next = ST_TSQ;
        end else if (comp == COMP_Z) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MAG;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hnm_dp.sv =====
// Datapath: row stores, frame position and the normal encoder.
`default_nettype none

module hnm_dp import hnm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  hnm_cmd_t      cmd,
  output hnm_status_t   status,
  input  logic          in_cmd,
  input  logic [7:0]    in_height,
  input  logic [7:0]    in_alpha,
  input  logic [WW-1:0] weff,
  input  logic [HW-1:0] heff,
  input  logic [15:0]   scale,
  input  logic          mirror,
  input  logic          pos_clear,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data,
  output logic          out_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Frame position.
  logic [AW-1:0] col, col_eff, col_inc, nb_addr;
  logic [HW-1:0] row, row_inc;
  logic          flushing, last_col, row_wrap, pix_ok, flush_ok;

  // Row stores and their read registers.
  logic [15:0] row_mem [MAX_WIDTH];
  logic [7:0]  top_mem [MAX_WIDTH];
  logic [15:0] rd_cur, rd_nb;
  logic [7:0]  rd_top;

  // Flags of the item being worked on.
  logic       e_pixel, e_last_col, e_col0, e_zdx, e_zdy, e_flast;
  logic [7:0] e_hv;
  logic [15:0] saved;

  // Arithmetic registers.
  logic [7:0]       adx, ady, alpha;
  logic             dxpos, dypos;
  logic [23:0]      mx, my;
  logic [LEN_W-1:0] len;
  logic [30:0]      mag;
  logic [61:0]      rhs;
  logic [6:0]       u;
  logic             eq;
  logic [13:0]      sq;
  logic [38:0]      plo, phi;
  logic [7:0]       nx, ny, nz;

  // Combinational helpers.
  logic [7:0]        right_c, lower_c;
  logic signed [8:0] dx_c, dy_c;
  logic [47:0]       sqx_c, sqy_c;
  logic [23:0]       cv_c;
  logic [30:0]       mag_c;
  logic [61:0]       rhs_c;
  logic [6:0]        trial_c, u_fin;
  logic [13:0]       sq_c;
  logic [38:0]       plo_c, phi_c;
  logic [63:0]       prod_c;
  logic              ok_c, eq_fin, neg_c;
  logic [7:0]        byte_c, right_sel, down_sel;
  logic [23:0]       mxs_c, mys_c;

  // Position decode.
  always_comb begin
    col_eff  = (WW'(col) >= weff) ? '0 : col;
    last_col = ((WW'(col_eff) + WW'(1)) == weff);
    col_inc  = AW'(col_eff + 1'b1);
    nb_addr  = last_col ? '0 : col_inc;
    row_inc  = HW'(row + 1'b1);
    row_wrap = (row_inc >= heff);
    pix_ok   = !flushing && (in_cmd == CMD_PIXEL);
    flush_ok = flushing && (in_cmd == CMD_FLUSH);
    status.will_emit = (pix_ok && (row != '0)) || flush_ok;
    status.out_free  = !out_valid || out_ready;
  end

  // Frame position counters.
  always_ff @(posedge clk) begin
    if (rst || pos_clear) begin
      col      <= '0;
      row      <= '0;
      flushing <= 1'b0;
    end else if (cmd.take && (pix_ok || flush_ok)) begin
      if (last_col) begin
        col <= '0;
        if (pix_ok) begin
          if (row_wrap) begin
            row      <= '0;
            flushing <= 1'b1;
          end else begin
            row <= row_inc;
          end
        end else begin
          row      <= '0;
          flushing <= 1'b0;
        end
      end else begin
        col <= col_inc;
      end
    end
  end

  // Row stores: read the old row, then overwrite the current column.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_cur <= row_mem[col_eff];
      rd_nb  <= row_mem[nb_addr];
      rd_top <= top_mem[col_eff];
      if (pix_ok) begin
        row_mem[col_eff] <= {in_alpha, in_height};
        if (row == '0) top_mem[col_eff] <= in_height;
      end
    end
  end

  // Capture the item's flags.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      e_pixel    <= pix_ok;
      e_last_col <= last_col;
      e_col0     <= (col_eff == '0);
      e_hv       <= in_height;
      e_zdx      <= mirror && last_col;
      e_zdy      <= flush_ok && mirror;
      e_flast    <= flush_ok && last_col;
    end
  end

  // Neighbor selection and differences.
  always_comb begin
    if (e_pixel && e_last_col) begin
      right_c = e_col0 ? rd_cur[7:0] : saved[7:0];
    end else begin
      right_c = rd_nb[7:0];
    end
    lower_c = e_pixel ? e_hv : rd_top;
    dx_c = e_zdx ? 9'sd0 : ($signed({1'b0, right_c}) - $signed({1'b0, rd_cur[7:0]}));
    dy_c = e_zdy ? 9'sd0 : ($signed({1'b0, lower_c}) - $signed({1'b0, rd_cur[7:0]}));
    right_sel = dx_c[8] ? 8'(-dx_c) : 8'(dx_c);
    down_sel  = dy_c[8] ? 8'(-dy_c) : 8'(dy_c);
  end

  // Encoder arithmetic, at most one product per step (two in the scale step).
  always_comb begin
    mxs_c = adx * scale;
    mys_c = ady * scale;
    sqx_c = mx * mx;
    sqy_c = my * my;
    case (cmd.comp)
      COMP_X:  cv_c = mx;
      COMP_Y:  cv_c = my;
      default: cv_c = 24'(Z_COMP);
    endcase
    case (cmd.comp)
      COMP_X:  neg_c = dxpos;
      COMP_Y:  neg_c = dypos;
      default: neg_c = 1'b0;
    endcase
    mag_c   = cv_c * NORM_MAX;
    rhs_c   = mag * mag;
    trial_c = u | (7'd1 << cmd.bitsel);
    sq_c    = trial_c * trial_c;
    plo_c   = sq * len[HALF_W-1:0];
    phi_c   = sq * len[LEN_W-1:HALF_W];
    prod_c  = {phi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo};
    ok_c    = (prod_c <= {2'b00, rhs});
    u_fin   = ok_c ? trial_c : u;
    eq_fin  = ok_c ? (prod_c == {2'b00, rhs}) : eq;
    // Negative components round toward minus infinity.
    if (neg_c) begin
      byte_c = ENC_MID - ({1'b0, u_fin} + {7'd0, !eq_fin});
    end else begin
      byte_c = ENC_MID + {1'b0, u_fin};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        adx   <= right_sel;
        ady   <= down_sel;
        dxpos <= !dx_c[8] && (dx_c != 9'sd0);
        dypos <= !dy_c[8] && (dy_c != 9'sd0);
        alpha <= rd_cur[15:8];
      end
      OP_SCALE: begin
        mx <= mxs_c;
        my <= mys_c;
      end
      OP_SQX: len <= LEN_W'(sqx_c) + LEN_W'(Z_SQ);
      OP_SQY: len <= len + LEN_W'(sqy_c);
      OP_MAG: begin
        mag <= mag_c;
        u   <= '0;
      end
      OP_RHS: begin
        rhs <= rhs_c;
        eq  <= (mag == '0);
      end
      OP_TSQ: sq <= sq_c;
      OP_PLO: plo <= plo_c;
      OP_PHI: phi <= phi_c;
      OP_CMP: begin
        u  <= u_fin;
        eq <= eq_fin;
        if (cmd.bitsel == 3'd0) begin
          case (cmd.comp)
            COMP_X:  nx <= byte_c;
            COMP_Y:  ny <= byte_c;
            default: nz <= byte_c;
          endcase
        end
      end
      OP_OUT: begin
        out_data <= {alpha, nz, ny, nx};
        out_last <= e_flast;
      end
      default: ;
    endcase
  end

  // Start of the previous row, needed for the wrap at its last column.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved <= '0;
    end else if (cmd.op == OP_LOAD && e_pixel && e_col0) begin
      saved <= rd_cur;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/height_to_normal_map.sv =====
// Top level: configuration registers, stream ports and the controller/datapath pair.
//
//  Port group  Direction  Contents
//  s_*         in         height/alpha words and flush words
//  m_*         out        encoded normal words, tlast on the final pixel
//  cfg_*       in         register writes, index 0..3
//
// A word that emits nothing is taken in the idle state. A word that emits a normal
// passes the take, four setup steps, then for each of the three components the
// MAG and RHS steps that form the target and a 7-step square-compare search whose
// steps each square a trial, form two partial products and compare, and an output step.
// Results lag one row; the last row is emitted by flush words.
// Reset is synchronous; the row stores are not cleared and need no clearing pass.
// A stalled output holds its word while the next input word is already taken.
`default_nettype none

module height_to_normal_map import hnm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // height_value, alpha_in
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // normal_x, normal_y, normal_z, alpha_out
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [10:0] width_reg, height_reg;
  logic [15:0] scale_reg;
  logic        mirror_reg, cfg_we, pos_clear;
  logic [WW-1:0] weff;
  logic [HW-1:0] heff;
  hnm_cmd_t    cmd;
  hnm_status_t status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign pos_clear = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd256;
      height_reg <= 11'd256;
      scale_reg  <= 16'd256;
      mirror_reg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data[10:0];
        REG_HEIGHT: height_reg <= cfg_data[10:0];
        REG_SCALE:  scale_reg  <= cfg_data;
        REG_MIRROR: mirror_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective image size: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (width_reg == 11'd0) begin
      weff = WW'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(width_reg);
    end
    if (height_reg == 11'd0) begin
      heff = HW'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      heff = HW'(MAX_HEIGHT);
    end else begin
      heff = HW'(height_reg);
    end
  end

  hnm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  hnm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_cmd    (s_tuser),
    .in_height (s_tdata[7:0]),
    .in_alpha  (s_tdata[15:8]),
    .weff      (weff),
    .heff      (heff),
    .scale     (scale_reg),
    .mirror    (mirror_reg),
    .pos_clear (pos_clear),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
